// ===== rtl/core/gpc_pkg.sv =====
// shared constants and helpers for the grid path counter
`default_nettype none

package gpc_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int ROWS_FIELD_WIDTH = 11;
    localparam int COLS_FIELD_WIDTH = 7;
    localparam int CFG_DATA_WIDTH   = 11;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int PATH_WIDTH       = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_GRID_ROWS    = 2'd0,
        REG_GRID_COLUMNS = 2'd1
    } cfg_reg_t;

    // clamp a size register to 1..max and return it minus one
    function automatic logic [31:0] size_last(input logic [31:0] value, input logic [31:0] max_v);
        logic [31:0] res;
        begin
            if (value == 32'd0) begin
                res = 32'd0;
            end else if (value > max_v) begin
                res = max_v - 32'd1;
            end else begin
                res = value - 32'd1;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gpc_cell.sv =====
// one cell of the row store chain, holds the count of one column
`default_nettype none

module gpc_cell #(
    parameter int COUNT_WIDTH = gpc_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                   aclk,
    input  wire logic                   shift_en,
    input  wire logic [COUNT_WIDTH-1:0] count_in,
    output logic      [COUNT_WIDTH-1:0] count_out
);
    import gpc_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            count_reg <= count_in;
        end
    end

    assign count_out = count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gpc_chain.sv =====
// chain of row store cells with a tap at the row length
`default_nettype none

module gpc_chain #(
    parameter int MAX_COLUMNS = gpc_pkg::DEF_MAX_COLUMNS,
    parameter int COUNT_WIDTH = gpc_pkg::DEF_COUNT_WIDTH,
    parameter int CW          = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   shift_en,
    input  wire logic [CW-1:0]          tap_sel,
    input  wire logic [COUNT_WIDTH-1:0] count_in,
    output logic      [COUNT_WIDTH-1:0] count_up
);
    import gpc_pkg::*;

    logic [COUNT_WIDTH-1:0] link [MAX_COLUMNS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_COLUMNS; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                gpc_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
                    .aclk      (aclk),
                    .shift_en  (shift_en),
                    .count_in  (count_in),
                    .count_out (link[gi])
                );
            end else begin : g_body
                gpc_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
                    .aclk      (aclk),
                    .shift_en  (shift_en),
                    .count_in  (link[gi-1]),
                    .count_out (link[gi])
                );
            end
        end
    endgenerate

    // value written one row ago sits at the last used cell
    assign count_up = link[tap_sel];

endmodule

`default_nettype wire

// ===== rtl/core/grid_path_count_with_obstacles.sv =====
// top level of the obstacle grid path counter
`default_nettype none

// Takes one grid cell per word in row-major order and returns one word with the
// saturated path count of the bottom-right cell at the end of each grid. A new
// cell is taken every clock cycle: one saturating add per cell, with the count
// of the cell above read from a chain of MAX_COLUMNS cells that shifts once per
// cell and is tapped at the row length. The result sits in an output register,
// so cells keep flowing while it waits; only the last cell of the next grid
// waits for it to be taken. A register write abandons the grid in progress.
module grid_path_count_with_obstacles #(
    parameter int MAX_COLUMNS = gpc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gpc_pkg::DEF_MAX_ROWS,
    parameter int COUNT_WIDTH = gpc_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [gpc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [gpc_pkg::CFG_DATA_WIDTH-1:0]    cfg_wr_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_blocked_cell,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic      [gpc_pkg::PATH_WIDTH-1:0]        m_path_count,
    output logic                                       m_count_saturated
);
    import gpc_pkg::*;

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int OW = (COUNT_WIDTH > PATH_WIDTH) ? COUNT_WIDTH : PATH_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [CW-1:0]          cols_last_reg, cols_last_next;
    logic [RW-1:0]          rows_last_reg, rows_last_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [COUNT_WIDTH-1:0] left_reg, left_next;
    logic                   sat_reg, sat_next;
    logic                   m_valid_reg, m_valid_next;
    logic [PATH_WIDTH-1:0]  path_reg, path_next;
    logic                   msat_reg, msat_next;

    logic                   cfg_hit;
    logic                   accept;
    logic                   col_last, row_last, grid_last;
    logic [COUNT_WIDTH-1:0] count_up, cell_count;
    logic [COUNT_WIDTH:0]   sum;
    logic                   sat_now;
    logic [OW-1:0]          count_ext;

    assign cfg_hit  = cfg_wr_en &&
                      (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLUMNS);
    assign col_last = (col_reg == cols_last_reg);
    assign row_last = (row_reg == rows_last_reg);
    assign grid_last = col_last && row_last;
    assign s_ready  = !m_valid_reg || m_ready || !grid_last;
    assign accept   = s_valid && s_ready;

    gpc_chain #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .CW          (CW)
    ) u_chain (
        .aclk     (aclk),
        .shift_en (accept),
        .tap_sel  (cols_last_reg),
        .count_in (cell_count),
        .count_up (count_up)
    );

    // cell count
    always_comb begin
        sum     = {1'b0, count_up} + {1'b0, left_reg};
        sat_now = 1'b0;
        if (s_blocked_cell) begin
            cell_count = '0;
        end else if (row_reg == '0 && col_reg == '0) begin
            cell_count = COUNT_WIDTH'(1);
        end else if (row_reg == '0) begin
            cell_count = left_reg;
        end else if (col_reg == '0) begin
            cell_count = count_up;
        end else if (sum[COUNT_WIDTH]) begin
            cell_count = COUNT_MAX;
            sat_now    = 1'b1;
        end else begin
            cell_count = sum[COUNT_WIDTH-1:0];
        end
        count_ext = OW'(cell_count);
    end

    always_comb begin
        cols_last_next = cols_last_reg;
        rows_last_next = rows_last_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        left_next      = left_reg;
        sat_next       = sat_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        path_next      = path_reg;
        msat_next      = msat_reg;
        if (cfg_hit) begin
            if (cfg_index == REG_GRID_ROWS) begin
                rows_last_next = RW'(size_last(32'(cfg_wr_data[ROWS_FIELD_WIDTH-1:0]),
                                               32'(MAX_ROWS)));
            end else begin
                cols_last_next = CW'(size_last(32'(cfg_wr_data[COLS_FIELD_WIDTH-1:0]),
                                               32'(MAX_COLUMNS)));
            end
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
            sat_next  = 1'b0;
        end else if (accept) begin
            if (col_last) begin
                col_next  = '0;
                left_next = '0;
                if (row_last) begin
                    row_next     = '0;
                    sat_next     = 1'b0;
                    m_valid_next = 1'b1;
                    msat_next    = sat_reg || sat_now;
                    if ((count_ext >> PATH_WIDTH) != '0) begin
                        path_next = {PATH_WIDTH{1'b1}};
                    end else begin
                        path_next = PATH_WIDTH'(count_ext);
                    end
                end else begin
                    row_next = row_reg + RW'(1);
                    sat_next = sat_reg || sat_now;
                end
            end else begin
                col_next  = col_reg + CW'(1);
                left_next = cell_count;
                sat_next  = sat_reg || sat_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_last_reg <= '0;
            rows_last_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            sat_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cols_last_reg <= cols_last_next;
            rows_last_reg <= rows_last_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            sat_reg       <= sat_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        path_reg <= path_next;
        msat_reg <= msat_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_path_count      = path_reg;
    assign m_count_saturated = msat_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gpc_checker.sv =====
// port level checks for the grid path counter, bound to the top level
`default_nettype none

module gpc_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                cfg_wr_en,
    input wire logic [gpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic [gpc_pkg::PATH_WIDTH-1:0]      m_path_count,
    input wire logic                                m_count_saturated
);
    import gpc_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_path_count) && $stable(m_count_saturated))
        else $error("result word changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    a_result_from_word: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted word");

    a_cfg_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLUMNS)
        |=> !$rose(m_valid))
        else $error("result emitted after grid was abandoned");

endmodule

bind grid_path_count_with_obstacles gpc_checker u_gpc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_path_count      (m_path_count),
    .m_count_saturated (m_count_saturated)
);

`default_nettype wire

// ===== tb/sv/tb_grid_path_count_with_obstacles.sv =====
// testbench for the obstacle grid path counter, random grids against a path-count predictor
`timescale 1ns / 100ps

module tb_grid_path_count_with_obstacles;
    import gpc_pkg::*;

    localparam int                      MAX_C        = DEF_MAX_COLUMNS;
    localparam int                      MAX_R        = DEF_MAX_ROWS;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 2'd2;
    localparam int                      RANDOM_CELLS = 1650;
    localparam int                      SETTLE       = 16;
    localparam int                      LONG_HOLD    = 300;

    typedef struct packed {
        logic [PATH_WIDTH-1:0] paths;
        logic                  saturated;
    } grid_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wr_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_blocked_cell = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [PATH_WIDTH-1:0]      m_path_count;
    logic                       m_count_saturated;

    // predictor state
    logic [PATH_WIDTH-1:0] above_counts [MAX_C];
    logic [PATH_WIDTH-1:0] left_paths;
    int unsigned           row_at;
    int unsigned           col_at;
    bit                    overflow_seen;
    logic [10:0]           rows_setting = 11'd1;
    logic [6:0]            cols_setting = 7'd1;

    grid_result_t pending_results [$];
    logic         cell_queue [$];
    bit           cell_taken;
    bit           word_taken;
    int           gap_left;
    int           stall_left;
    int           hold_req;
    bit           tx_pauses;
    bit           rx_pauses;
    int           mismatches;
    int           random_cells;

    grid_path_count_with_obstacles u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_blocked_cell    (s_blocked_cell),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_path_count      (m_path_count),
        .m_count_saturated (m_count_saturated)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned clamp_size(input int unsigned value, input int unsigned top);
        if (value == 0) return 1;
        return (value > top) ? top : value;
    endfunction

    function automatic int pick_pause(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 31);
        if (r < 20) return 0;
        if (r < 30) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic restart_grid;
        left_paths    = '0;
        row_at        = 0;
        col_at        = 0;
        overflow_seen = 1'b0;
    endtask

    task automatic count_cell(input logic blocked);
        int unsigned           nrows;
        int unsigned           ncols;
        logic [PATH_WIDTH:0]   total;
        logic [PATH_WIDTH-1:0] cell_val;
        grid_result_t          res;
        nrows = clamp_size(rows_setting, MAX_R);
        ncols = clamp_size(cols_setting, MAX_C);
        if (blocked) begin
            cell_val = '0;
        end else if (row_at == 0 && col_at == 0) begin
            cell_val = PATH_WIDTH'(1);
        end else if (row_at == 0) begin
            cell_val = left_paths;
        end else if (col_at == 0) begin
            cell_val = above_counts[col_at];
        end else begin
            total = {1'b0, above_counts[col_at]} + {1'b0, left_paths};
            if (total[PATH_WIDTH]) begin
                cell_val      = '1;
                overflow_seen = 1'b1;
            end else begin
                cell_val = total[PATH_WIDTH-1:0];
            end
        end
        above_counts[col_at] = cell_val;
        left_paths           = cell_val;
        if (col_at + 1 >= ncols) begin
            if (row_at + 1 >= nrows) begin
                res.paths     = cell_val;
                res.saturated = overflow_seen;
                pending_results.push_back(res);
                restart_grid();
            end else begin
                col_at     = 0;
                left_paths = '0;
                row_at     = row_at + 1;
            end
        end else begin
            col_at = col_at + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else if (!s_valid || cell_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (cell_queue.size() > 0) begin
                s_valid        <= 1'b1;
                s_blocked_cell <= cell_queue.pop_front();
                gap_left = pick_pause(tx_pauses);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0 && hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end else if (stall_left == 0) begin
                stall_left = pick_pause(rx_pauses);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        grid_result_t want;
        cell_taken = aresetn && s_valid && s_ready;
        word_taken = aresetn && m_valid && m_ready;
        if (cell_taken)
            count_cell(s_blocked_cell);
        if (word_taken) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with none expected", m_path_count, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_path_count !== want.paths)
                    report_mismatch("path_count", m_path_count, want.paths);
                if (m_count_saturated !== want.saturated)
                    report_mismatch("count_saturated", 32'(m_count_saturated),
                                    32'(want.saturated));
            end
        end
    end

    task automatic wait_drained;
        while (cell_queue.size() != 0 || s_valid || pending_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_GRID_ROWS: begin
                rows_setting = value;
                restart_grid();
            end
            REG_GRID_COLUMNS: begin
                cols_setting = value[6:0];
                restart_grid();
            end
            default: ;
        endcase
    endtask

    task automatic offer(input int n, input logic [15:0] pattern);
        for (int i = n - 1; i >= 0; i--)
            cell_queue.push_back(pattern[i]);
    endtask

    task automatic queue_grids(input logic [10:0] rows_val, input logic [10:0] cols_val,
                               input int grids, input int density, input bit leave_partial);
        int area;
        int extra;
        write_reg(REG_GRID_ROWS, rows_val);
        write_reg(REG_GRID_COLUMNS, cols_val);
        area  = clamp_size(rows_val, MAX_R) * clamp_size(cols_val[6:0], MAX_C);
        extra = (leave_partial && area > 1) ? $urandom_range(1, area - 1) : 0;
        repeat (grids * area + extra)
            cell_queue.push_back($urandom_range(0, 15) < density);
        random_cells += grids * area + extra;
    endtask

    initial begin
        int          pick;
        int          density;
        logic [10:0] wide;
        restart_grid();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset sizes, zero sizes, small grids, abandoned grid
        offer(2, 2'b01);
        write_reg(REG_GRID_ROWS, 11'd0);
        write_reg(REG_GRID_COLUMNS, 11'd0);
        offer(2, 2'b10);
        write_reg(REG_GRID_ROWS, 11'd2);
        write_reg(REG_GRID_COLUMNS, 11'd2);
        offer(8, 8'b0000_1000);
        offer(2, 2'b00);
        write_reg(REG_UNMAPPED, 11'h5a5);
        offer(2, 2'b00);
        offer(1, 1'b0);
        write_reg(REG_GRID_ROWS, 11'd3);
        write_reg(REG_GRID_COLUMNS, 11'd3);
        offer(9, 9'b000_010_000);

        // tallest grid, rows above the maximum
        tx_pauses = 1'b0;
        rx_pauses = 1'b1;
        queue_grids(11'd2047, 11'd1, 1, 0, 1'b0);

        // saturating grid
        tx_pauses = 1'b1;
        queue_grids(11'd19, 11'd19, 1, 0, 1'b0);

        // receiver holds off while single-cell grids keep coming
        tx_pauses = 1'b0;
        queue_grids(11'd1, 11'd1, 40, 4, 1'b0);
        hold_req = LONG_HOLD;

        while (random_cells < RANDOM_CELLS) begin
            tx_pauses = $urandom_range(0, 3) != 0;
            rx_pauses = $urandom_range(0, 3) != 0;
            pick      = $urandom_range(0, 15);
            case ($urandom_range(0, 5))
                0: density = 0;
                1: density = 1;
                2: density = 2;
                3: density = 4;
                4: density = 8;
                default: density = 12;
            endcase
            if (pick < 8) begin
                queue_grids(11'($urandom_range(1, 6)), 11'($urandom_range(1, 8)),
                            $urandom_range(3, 8), density, $urandom_range(0, 2) == 0);
            end else if (pick < 10) begin
                case ($urandom_range(0, 2))
                    0: wide = 11'd64;
                    1: wide = 11'd127;
                    default: wide = 11'($urandom_range(128, 2047));
                endcase
                queue_grids(11'($urandom_range(1, 3)), wide, $urandom_range(1, 2), density,
                            $urandom_range(0, 2) == 0);
            end else if (pick == 10) begin
                queue_grids(($urandom_range(0, 3) == 0) ? 11'd0 : 11'($urandom_range(20, 48)),
                            11'($urandom_range(0, 2)), 1, density, $urandom_range(0, 2) == 0);
            end else if (pick == 11) begin
                queue_grids(11'($urandom_range(15, 18)), 11'($urandom_range(24, 34)), 1,
                            $urandom_range(0, 1), 1'b0);
            end else if (pick < 14) begin
                queue_grids(11'($urandom_range(0, 1)), 11'($urandom_range(0, 1)),
                            $urandom_range(10, 30), density, 1'b0);
            end else begin
                queue_grids(11'($urandom_range(2, 10)), 11'($urandom_range(2, 10)),
                            $urandom_range(1, 3), density, $urandom_range(0, 2) == 0);
            end
        end

        wait_drained();
        repeat (SETTLE) @(negedge aclk);
        if (mismatches == 0)
            $display("tb_grid_path_count_with_obstacles: done, clean");
        else
            $display("tb_grid_path_count_with_obstacles: done, errors");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb_grid_path_count_with_obstacles: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gpc_pkg.sv
rtl/core/gpc_cell.sv
rtl/core/gpc_chain.sv
rtl/core/grid_path_count_with_obstacles.sv
rtl/core/gpc_checker.sv
tb/sv/tb_grid_path_count_with_obstacles.sv
